### sv/lsfd_pkg.sv
// Shared types, constants and color tables for the LED sparkle frame decay block.
// Used by the channel interfaces, the cell and head modules and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lsfd_pkg;

    // Strip geometry
    localparam int PIXEL_COUNT = 64;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 8;
    localparam int PICK_W      = 8;
    localparam int CHAN_W      = 8;

    // Last pixel index of a frame
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

    // One RGB pixel
    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_pixel;

    // Sparkle to merge into the frame, latched when a beat is taken
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             pos_ok;
        t_pixel           color;
        t_pixel           dim;
    } t_sparkle;

    // Frame sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Sparkle color for a pick; above fifteen is black
    function automatic t_pixel pick_color(input logic [PICK_W-1:0] pick);
        t_pixel c;
        if (pick == PICK_W'(0)) begin
            c = '{r: 8'd255, g: 8'd220, b: 8'd255};
        end else if (pick == PICK_W'(1)) begin
            c = '{r: 8'd220, g: 8'd255, b: 8'd255};
        end else if (pick <= PICK_W'(4)) begin
            c = '{r: 8'd80, g: 8'd128, b: 8'd255};
        end else if (pick <= PICK_W'(15)) begin
            c = '{r: 8'd30, g: 8'd70, b: 8'd205};
        end else begin
            c = '{r: 8'd0, g: 8'd0, b: 8'd0};
        end
        return c;
    endfunction

    // Neighbor color: each channel of the pick color divided by three
    function automatic t_pixel dim_color(input logic [PICK_W-1:0] pick);
        t_pixel c;
        if (pick == PICK_W'(0)) begin
            c = '{r: 8'd85, g: 8'd73, b: 8'd85};
        end else if (pick == PICK_W'(1)) begin
            c = '{r: 8'd73, g: 8'd85, b: 8'd85};
        end else if (pick <= PICK_W'(4)) begin
            c = '{r: 8'd26, g: 8'd42, b: 8'd85};
        end else if (pick <= PICK_W'(15)) begin
            c = '{r: 8'd10, g: 8'd23, b: 8'd68};
        end else begin
            c = '{r: 8'd0, g: 8'd0, b: 8'd0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/lsfd_in_if.sv
// Input channel: one beat per animation frame (sparkle position and color pick).
// Depends on lsfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsfd_in_if import lsfd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  sparkle_pos;
    logic [PICK_W-1:0] color_pick;

    modport source (output valid, output sparkle_pos, output color_pick, input ready);
    modport sink   (input valid, input sparkle_pos, input color_pick, output ready);

endinterface

`default_nettype wire

### sv/lsfd_out_if.sv
// Output channel: one beat per pixel of the streamed frame.
// Depends on lsfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsfd_out_if import lsfd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output frame_end, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input frame_end, output ready);

endinterface

`default_nettype wire

### sv/lsfd_cell.sv
// One pixel cell of the frame ring; loads its neighbor's pixel on each shift.
// Depends on lsfd_pkg for the pixel type.
`timescale 1ns / 1ps
`default_nettype none

module lsfd_cell import lsfd_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_shift,
    input  t_pixel i_pix,
    output t_pixel o_pix
);

    t_pixel r_pix;

    // Pixel storage, cleared to black on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

`default_nettype wire

### sv/lsfd_head.sv
// Head of the ring: merges the sparkle into the pixel at the front and decays it.
// Depends on lsfd_pkg for the pixel and sparkle types.
`timescale 1ns / 1ps
`default_nettype none

module lsfd_head import lsfd_pkg::*; (
    input  t_pixel           i_pix,
    input  logic [IDX_W-1:0] i_idx,
    input  t_sparkle         i_spk,
    output t_pixel           o_pix
);

    logic [POS_W:0] w_idx_ext;
    logic [POS_W:0] w_pos_ext;
    logic           w_center;
    logic           w_side;
    t_pixel         w_merged;

    // Position compares, one bit wider so pos+1 and idx+1 cannot wrap
    assign w_idx_ext = (POS_W+1)'(i_idx);
    assign w_pos_ext = (POS_W+1)'(i_spk.pos);
    assign w_center  = i_spk.pos_ok && (w_idx_ext == w_pos_ext);
    assign w_side    = i_spk.pos_ok && ((w_idx_ext + 1'b1 == w_pos_ext) ||
                                        (w_idx_ext == w_pos_ext + 1'b1));

    // Sparkle overwrite
    always_comb begin
        if (w_center) begin
            w_merged = i_spk.color;
        end else if (w_side) begin
            w_merged = i_spk.dim;
        end else begin
            w_merged = i_pix;
        end
    end

    // Decay: nonzero channels drop by one
    assign o_pix.r = w_merged.r - CHAN_W'(w_merged.r != '0);
    assign o_pix.g = w_merged.g - CHAN_W'(w_merged.g != '0);
    assign o_pix.b = w_merged.b - CHAN_W'(w_merged.b != '0);

endmodule

`default_nettype wire

### sv/led_sparkle_frame_decay.sv
// Top level of the LED sparkle frame decay block: sequencer, head and ring of cells.
// Depends on lsfd_pkg, lsfd_in_if, lsfd_out_if, lsfd_cell and lsfd_head.
//
//   Port   Dir  Beat                         Fields
//   i_in   in   one animation frame          sparkle_pos, color_pick
//   o_out  out  one pixel, index order       pixel_index, red, green, blue, frame_end
//
// A frame is one input beat taken while idle, then one output beat per cycle while
// the output does not stall, set by the ring of pixel cells that rotates one place
// per emitted pixel.
// Reset (synchronous, active low) clears every pixel to black and idles the block.
// An output stall freezes the ring; a new frame is taken only after frame_end.
`timescale 1ns / 1ps
`default_nettype none

module led_sparkle_frame_decay import lsfd_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lsfd_in_if.sink      i_in,
    lsfd_out_if.source   o_out
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    t_sparkle         r_spk;
    logic             w_in_take;
    logic             w_out_take;
    logic             w_last;
    t_pixel           w_new;
    t_pixel           w_cell [PIXEL_COUNT];

    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_out_take = o_out.valid && o_out.ready;
    assign w_last     = (r_idx == LAST_IDX);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_out.ready && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        case (r_state)
            ST_IDLE: begin
                i_in.ready  = 1'b1;
                o_out.valid = 1'b0;
            end
            ST_RUN: begin
                i_in.ready  = 1'b0;
                o_out.valid = 1'b1;
            end
            default: begin
                i_in.ready  = 1'b0;
                o_out.valid = 1'b0;
            end
        endcase
    end

    // Pixel counter
    always_comb begin
        n_idx = r_idx;
        if (w_out_take) begin
            n_idx = w_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Sparkle latched with the input beat
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_spk.pos    <= i_in.sparkle_pos;
            r_spk.pos_ok <= ((POS_W+1)'(i_in.sparkle_pos) < (POS_W+1)'(PIXEL_COUNT));
            r_spk.color  <= pick_color(i_in.color_pick);
            r_spk.dim    <= dim_color(i_in.color_pick);
        end
    end

    // Merge and decay of the front pixel
    lsfd_head u_head (
        .i_pix (w_cell[0]),
        .i_idx (r_idx),
        .i_spk (r_spk),
        .o_pix (w_new)
    );

    // Ring of cells: front pixel goes out and its updated value enters the tail
    for (genvar gi = 0; gi < PIXEL_COUNT; gi++) begin : g_ring
        t_pixel w_feed;
        if (gi == PIXEL_COUNT - 1) begin : g_tail
            assign w_feed = w_new;
        end else begin : g_mid
            assign w_feed = w_cell[gi+1];
        end
        lsfd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_out_take),
            .i_pix   (w_feed),
            .o_pix   (w_cell[gi])
        );
    end

    // Output beat
    assign o_out.pixel_index = r_idx;
    assign o_out.red         = w_new.r;
    assign o_out.green       = w_new.g;
    assign o_out.blue        = w_new.b;
    assign o_out.frame_end   = w_last;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a frame is streaming");

    a_start_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (o_out.valid && r_idx == '0))
        else $error("frame did not start streaming at pixel zero");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && o_out.frame_end) |=> i_in.ready)
        else $error("block not idle after last pixel");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_idx == '0))
        else $error("pixel counter not at zero while idle");
`endif

endmodule

`default_nettype wire
